// ===== src/gasp_pkg.sv =====
`timescale 1ns / 1ps

package gasp_pkg;

    localparam int MAX_PAGES = 8;
    localparam int PG_W      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W     = $clog2(MAX_PAGES + 1);
    localparam int DIM_W     = 13;
    localparam int GLY_W     = 11;
    localparam int PAD_W     = 6;
    localparam int SUM_W     = 15;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd1024;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd1024;
    localparam logic [PAD_W-1:0] PAD_RESET    = 6'd4;

    typedef enum logic [1:0] {
        REG_ATLAS_WIDTH  = 2'd0,
        REG_ATLAS_HEIGHT = 2'd1,
        REG_PAD_BORDER   = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_PLACED_OPEN = 3'd0,
        ST_PLACED_NEW  = 3'd1,
        ST_TOO_LARGE   = 3'd2,
        ST_PAGES_FULL  = 3'd3,
        ST_CLEARED     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PADW,
        S_PADH,
        S_FITX,
        S_WRAP,
        S_FITY,
        S_COMMIT,
        S_NEW
    } t_state;

    typedef struct packed {
        logic             cmd;
        logic [GLY_W-1:0] glyph_width;
        logic [GLY_W-1:0] glyph_height;
    } t_in_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  page_index;
        logic [11:0] place_x;
        logic [11:0] place_y;
    } t_out_res;

    typedef struct packed {
        logic [SUM_W-2:0] a;
        logic [SUM_W-2:0] b;
        logic [DIM_W-1:0] limit;
    } t_alu_req;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             over;
    } t_alu_res;

    typedef struct packed {
        logic [DIM_W-1:0] cx;
        logic [DIM_W-1:0] cy;
        logic [DIM_W-1:0] tall;
    } t_pg_entry;

    typedef struct packed {
        logic            en;
        logic [PG_W-1:0] idx;
        t_pg_entry       data;
    } t_pg_wr;

    typedef struct packed {
        logic [DIM_W-1:0] atlas_width;
        logic [DIM_W-1:0] atlas_height;
        logic [PAD_W-1:0] pad_border;
    } t_cfg;

endpackage

// ===== src/glyph_atlas_shelf_packer_unit.sv =====
// sequence: a clear is answered from idle; other requests pad width, then height (too
// large ends here), then walk open pages first fit (width check, row wrap if needed,
// height check) and end in a commit to an open page, a new page or pages full
// throughput: one request at a time, bounded by the shared adder/compare unit, the page
// walk and a stalled result output; reset: synchronous active low; clears sequencer,
// page count and result valid and restores the atlas registers to their reset values
`timescale 1ns / 1ps

module glyph_atlas_shelf_packer_unit
    import gasp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_req          i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_res         o_out_data,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [DIM_W-1:0] i_cfg_data
);

    t_cfg     r_cfg;
    logic     r_out_valid;
    t_out_res r_out_data;
    logic     busy;
    logic     res_valid;
    logic     res_take;
    t_out_res res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.atlas_width  <= WIDTH_RESET;
            r_cfg.atlas_height <= HEIGHT_RESET;
            r_cfg.pad_border   <= PAD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ATLAS_WIDTH:  r_cfg.atlas_width  <= i_cfg_data;
                REG_ATLAS_HEIGHT: r_cfg.atlas_height <= i_cfg_data;
                REG_PAD_BORDER:   r_cfg.pad_border   <= i_cfg_data[PAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign res_take = !r_out_valid || !i_out_stall;

    gasp_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req_valid (i_in_valid),
        .i_req       (i_in_data),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    // output register parts the sequencer from the result side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_out_data <= res;
        end
    end

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== src/gasp_alu.sv =====
`timescale 1ns / 1ps

module gasp_alu
    import gasp_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_res o_res
);

    logic [SUM_W-1:0] sum;

    assign sum        = {1'b0, i_req.a} + {1'b0, i_req.b};
    assign o_res.sum  = sum;
    assign o_res.over = sum > {{(SUM_W-DIM_W){1'b0}}, i_req.limit};

endmodule

// ===== src/gasp_page_store.sv =====
`timescale 1ns / 1ps

module gasp_page_store
    import gasp_pkg::*;
(
    input  logic            i_clk,
    input  t_pg_wr          i_wr,
    input  logic [PG_W-1:0] i_rd_idx,
    output t_pg_entry       o_rd
);

    t_pg_entry r_pages [MAX_PAGES];
    t_pg_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_pages[i_wr.idx] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_pages[i_rd_idx];
    end

    assign o_rd = r_rd;

endmodule

// ===== src/gasp_seq.sv =====
`timescale 1ns / 1ps

module gasp_seq
    import gasp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_req_valid,
    input  t_in_req  i_req,
    output logic     o_busy,
    output logic     o_res_valid,
    output t_out_res o_res,
    input  logic     i_res_take
);

    t_state           r_state, n_state;
    logic             r_done, n_done;
    logic [GLY_W-1:0] r_gw, n_gw;
    logic [GLY_W-1:0] r_gh, n_gh;
    logic [DIM_W-1:0] r_w, n_w;
    logic [DIM_W-1:0] r_h, n_h;
    logic             r_big, n_big;
    logic             r_wrap, n_wrap;
    logic [PG_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0] r_pages, n_pages;
    logic [DIM_W-1:0] r_cx, n_cx;
    logic [SUM_W-2:0] r_cy, n_cy;
    t_status          r_status, n_status;
    logic [PG_W-1:0]  r_pg, n_pg;
    logic [DIM_W-1:0] r_px, n_px;
    logic [DIM_W-1:0] r_py, n_py;

    t_alu_req         alu_req;
    t_alu_res         alu_res;
    t_pg_wr           pg_wr;
    t_pg_entry        pg_rd;
    logic [SUM_W-2:0] pad2;
    logic [CNT_W-1:0] idx_next;
    logic [DIM_W-1:0] tall_base;

    gasp_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    gasp_page_store u_store (
        .i_clk    (i_clk),
        .i_wr     (pg_wr),
        .i_rd_idx (n_idx),
        .o_rd     (pg_rd)
    );

    assign pad2     = {{(SUM_W-PAD_W-2){1'b0}}, i_cfg.pad_border, 1'b0};
    assign idx_next = CNT_W'({{(CNT_W-PG_W){1'b0}}, r_idx} + 1'b1);
    assign tall_base = (r_wrap && (pg_rd.cx != '0)) ? '0 : pg_rd.tall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_pages <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_pages <= n_pages;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gw     <= n_gw;
        r_gh     <= n_gh;
        r_w      <= n_w;
        r_h      <= n_h;
        r_big    <= n_big;
        r_wrap   <= n_wrap;
        r_idx    <= n_idx;
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_status <= n_status;
        r_pg     <= n_pg;
        r_px     <= n_px;
        r_py     <= n_py;
    end

    always_comb begin
        n_state  = r_state;
        n_done   = r_done;
        n_gw     = r_gw;
        n_gh     = r_gh;
        n_w      = r_w;
        n_h      = r_h;
        n_big    = r_big;
        n_wrap   = r_wrap;
        n_idx    = r_idx;
        n_pages  = r_pages;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_status = r_status;
        n_pg     = r_pg;
        n_px     = r_px;
        n_py     = r_py;
        alu_req  = '0;
        pg_wr    = '0;

        case (r_state)
            S_IDLE: begin
                if (r_done) begin
                    if (i_res_take) begin
                        n_done = 1'b0;
                    end
                end else if (i_req_valid) begin
                    n_gw = i_req.glyph_width;
                    n_gh = i_req.glyph_height;
                    if (i_req.cmd) begin
                        n_pages  = '0;
                        n_status = ST_CLEARED;
                        n_pg     = '0;
                        n_px     = '0;
                        n_py     = '0;
                        n_done   = 1'b1;
                    end else begin
                        n_state = S_PADW;
                    end
                end
            end
            S_PADW: begin
                alu_req.a     = {{(SUM_W-1-GLY_W){1'b0}}, r_gw};
                alu_req.b     = pad2;
                alu_req.limit = i_cfg.atlas_width;
                n_w           = alu_res.sum[DIM_W-1:0];
                n_big         = alu_res.over;
                n_state       = S_PADH;
            end
            S_PADH: begin
                alu_req.a     = {{(SUM_W-1-GLY_W){1'b0}}, r_gh};
                alu_req.b     = pad2;
                alu_req.limit = i_cfg.atlas_height;
                n_h           = alu_res.sum[DIM_W-1:0];
                n_idx         = '0;
                if (r_big || alu_res.over) begin
                    n_status = ST_TOO_LARGE;
                    n_pg     = '0;
                    n_px     = '0;
                    n_py     = '0;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_pages == '0) begin
                    n_state = S_NEW;
                end else begin
                    n_state = S_FITX;
                end
            end
            S_FITX: begin
                alu_req.a     = {{(SUM_W-1-DIM_W){1'b0}}, pg_rd.cx};
                alu_req.b     = {{(SUM_W-1-DIM_W){1'b0}}, r_w};
                alu_req.limit = i_cfg.atlas_width;
                n_wrap        = alu_res.over;
                n_cx          = alu_res.over ? '0 : pg_rd.cx;
                n_cy          = {{(SUM_W-1-DIM_W){1'b0}}, pg_rd.cy};
                n_state       = alu_res.over ? S_WRAP : S_FITY;
            end
            S_WRAP: begin
                alu_req.a     = r_cy;
                alu_req.b     = {{(SUM_W-1-DIM_W){1'b0}}, pg_rd.tall};
                alu_req.limit = i_cfg.atlas_height;
                n_cy          = alu_res.sum[SUM_W-2:0];
                n_state       = S_FITY;
            end
            S_FITY: begin
                alu_req.a     = r_cy;
                alu_req.b     = {{(SUM_W-1-DIM_W){1'b0}}, r_h};
                alu_req.limit = i_cfg.atlas_height;
                if (!alu_res.over) begin
                    n_state = S_COMMIT;
                end else if (idx_next != r_pages) begin
                    n_idx   = idx_next[PG_W-1:0];
                    n_state = S_FITX;
                end else if (r_pages < CNT_W'(MAX_PAGES)) begin
                    n_state = S_NEW;
                end else begin
                    n_status = ST_PAGES_FULL;
                    n_pg     = '0;
                    n_px     = '0;
                    n_py     = '0;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_COMMIT: begin
                alu_req.a      = {{(SUM_W-1-DIM_W){1'b0}}, r_cx};
                alu_req.b      = {{(SUM_W-1-DIM_W){1'b0}}, r_w};
                alu_req.limit  = i_cfg.atlas_width;
                pg_wr.en       = 1'b1;
                pg_wr.idx      = r_idx;
                pg_wr.data.cx  = alu_res.sum[DIM_W-1:0];
                pg_wr.data.cy  = r_cy[DIM_W-1:0];
                pg_wr.data.tall = (r_h > tall_base) ? r_h : tall_base;
                n_status       = ST_PLACED_OPEN;
                n_pg           = r_idx;
                n_px           = r_cx;
                n_py           = r_cy[DIM_W-1:0];
                n_done         = 1'b1;
                n_state        = S_IDLE;
            end
            S_NEW: begin
                pg_wr.en        = 1'b1;
                pg_wr.idx       = r_pages[PG_W-1:0];
                pg_wr.data.cx   = r_w;
                pg_wr.data.cy   = '0;
                pg_wr.data.tall = r_h;
                n_pages         = CNT_W'(r_pages + 1'b1);
                n_status        = ST_PLACED_NEW;
                n_pg            = r_pages[PG_W-1:0];
                n_px            = '0;
                n_py            = '0;
                n_done          = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy           = (r_state != S_IDLE) || r_done;
    assign o_res_valid      = r_done;
    assign o_res.status     = r_status;
    assign o_res.page_index = 3'(r_pg);
    assign o_res.place_x    = r_px[11:0];
    assign o_res.place_y    = r_py[11:0];

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import gasp_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int TAIL_CYCLES = 64;

    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_MOSTLY,
        RX_BURSTY
    } t_rx_mode;

    logic             i_clk     = 1'b0;
    logic             i_rst_n   = 1'b0;
    logic             in_valid  = 1'b0;
    t_in_req          in_data   = '0;
    logic             out_stall = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [1:0]       cfg_index = '0;
    logic [DIM_W-1:0] cfg_data  = '0;
    logic             o_in_stall;
    logic             o_out_valid;
    t_out_res         o_out_data;

    // own copy of the atlas registers and the shelf state
    int unsigned atlas_w = WIDTH_RESET;
    int unsigned atlas_h = HEIGHT_RESET;
    int unsigned border  = PAD_RESET;
    int unsigned shelf_x[MAX_PAGES];
    int unsigned shelf_y[MAX_PAGES];
    int unsigned shelf_tall[MAX_PAGES];
    int unsigned pages_used = 0;

    t_in_req  glyph_req_q[$];
    t_out_res placement_q[$];

    int fails         = 0;
    int reqs_sent     = 0;
    int settings_used = 1;
    int status_seen[5];
    int burst_left    = 0;
    int gap_left      = 0;
    int idle_cycles   = 0;
    int stall_tick    = 0;
    int mode_left     = 0;
    t_rx_mode rx_mode = RX_FREE;

    always #2 i_clk = ~i_clk;

    glyph_atlas_shelf_packer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    function automatic t_out_res predict_placement(t_in_req req);
        int unsigned w, h, cx, cy, px, py, pg;
        bit hit;
        t_out_res res;
        res = '0;
        px  = 0;
        py  = 0;
        pg  = 0;
        hit = 1'b0;
        if (req.cmd) begin
            for (int i = 0; i < MAX_PAGES; i++) begin
                shelf_x[i]    = 0;
                shelf_y[i]    = 0;
                shelf_tall[i] = 0;
            end
            pages_used = 0;
            res.status = ST_CLEARED;
            return res;
        end
        w = req.glyph_width + 2 * border;
        h = req.glyph_height + 2 * border;
        if (w > atlas_w || h > atlas_h) begin
            res.status = ST_TOO_LARGE;
            return res;
        end
        // first fit over open pages, wrapping to the next row when needed
        for (int i = 0; i < pages_used && !hit; i++) begin
            cx = shelf_x[i];
            cy = shelf_y[i];
            if (cx + w > atlas_w) begin
                cx = 0;
                cy += shelf_tall[i];
            end
            if (cy + h <= atlas_h) begin
                hit = 1'b1;
                pg  = i;
                px  = cx;
                py  = cy;
            end
        end
        if (hit) begin
            res.status = ST_PLACED_OPEN;
        end else if (pages_used < MAX_PAGES) begin
            pg = pages_used;
            pages_used++;
            shelf_x[pg]    = 0;
            shelf_y[pg]    = 0;
            shelf_tall[pg] = 0;
            res.status     = ST_PLACED_NEW;
        end else begin
            res.status = ST_PAGES_FULL;
            return res;
        end
        if (px == 0 && shelf_x[pg] != 0) begin
            shelf_tall[pg] = 0;
        end
        shelf_x[pg] = (px + w) & 32'h1fff;
        shelf_y[pg] = py & 32'h1fff;
        if (h > shelf_tall[pg]) begin
            shelf_tall[pg] = h & 32'h1fff;
        end
        res.page_index = pg[2:0];
        res.place_x    = px[11:0];
        res.place_y    = py[11:0];
        return res;
    endfunction

    function automatic bit work_pending();
        return glyph_req_q.size() != 0 || in_valid || placement_q.size() != 0;
    endfunction

    // request driver, bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                placement_q = {placement_q, predict_placement(in_data)};
                reqs_sent++;
            end
            if (!in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (glyph_req_q.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data  <= glyph_req_q.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with its own stall pattern
    always @(posedge i_clk) begin : result_monitor
        t_out_res want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (placement_q.size() == 0) begin
                $error("result with nothing pending: status %0d", o_out_data.status);
                fails++;
            end else begin
                want = placement_q.pop_front();
                if (want.status < 5) begin
                    status_seen[want.status]++;
                end
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d got %0d", want.status, o_out_data.status);
                    fails++;
                end
                if (o_out_data.page_index !== want.page_index) begin
                    $error("page_index: expected %0d got %0d",
                           want.page_index, o_out_data.page_index);
                    fails++;
                end
                if (o_out_data.place_x !== want.place_x) begin
                    $error("place_x: expected %0d got %0d", want.place_x, o_out_data.place_x);
                    fails++;
                end
                if (o_out_data.place_y !== want.place_y) begin
                    $error("place_y: expected %0d got %0d", want.place_y, o_out_data.place_y);
                    fails++;
                end
            end
        end
        if (mode_left == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(40, 200);
        end else begin
            mode_left--;
        end
        stall_tick++;
        case (rx_mode)
            RX_FREE: begin
                out_stall <= 1'b0;
            end
            RX_COIN: begin
                out_stall <= 1'($urandom_range(0, 1));
            end
            RX_MOSTLY: begin
                out_stall <= (stall_tick % 4) != 0;
            end
            default: begin
                out_stall <= (stall_tick % 16) < 5;
            end
        endcase
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) || !work_pending()) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic push_req(bit cmd, int gw, int gh);
        t_in_req req;
        req.cmd          = cmd;
        req.glyph_width  = gw[GLY_W-1:0];
        req.glyph_height = gh[GLY_W-1:0];
        glyph_req_q = {glyph_req_q, req};
    endtask

    task automatic settle();
        do @(negedge i_clk); while (work_pending());
    endtask

    task automatic load_atlas(int unsigned w, int unsigned h, int unsigned pad);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ATLAS_WIDTH;
        cfg_data  <= w[DIM_W-1:0];
        @(posedge i_clk);
        cfg_index <= REG_ATLAS_HEIGHT;
        cfg_data  <= h[DIM_W-1:0];
        @(posedge i_clk);
        cfg_index <= REG_PAD_BORDER;
        cfg_data  <= pad[DIM_W-1:0];
        @(posedge i_clk);
        cfg_we  <= 1'b0;
        atlas_w = w;
        atlas_h = h;
        border  = pad;
        settings_used++;
        @(negedge i_clk);
    endtask

    // mostly sizes that fit, with edge sizes and oversize mixed in
    function automatic int pick_dim(int unsigned limit);
        int fit;
        int cap;
        fit = int'(limit) - 2 * int'(border);
        cap = (limit / 6 > 2047) ? 2047 : int'(limit / 6);
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 2047);
            1: return 0;
            2: return 2047;
            3: return (fit < 0) ? 0 : ((fit > 2047) ? 2047 : fit);
            4: return (fit + 1 < 1) ? 1 : ((fit + 1 > 2047) ? 2047 : fit + 1);
            default: return $urandom_range(0, cap);
        endcase
    endfunction

    task automatic run_glyphs(int n);
        for (int i = 0; i < n; i++) begin
            push_req($urandom_range(0, 39) == 0, pick_dim(atlas_w), pick_dim(atlas_h));
        end
        settle();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_req(1, 0, 0);
        push_req(1, 2047, 2047);
        push_req(0, 0, 0);
        push_req(0, 1017, 0);
        push_req(0, 0, 1017);
        push_req(0, 2047, 2047);
        push_req(0, 1016, 1016);
        push_req(0, 500, 100);
        push_req(0, 600, 20);
        push_req(0, 1016, 0);
        for (int i = 0; i < 6; i++) begin
            push_req(0, 1016, 1016);
        end
        push_req(0, 1016, 1016);
        push_req(0, 10, 10);
        push_req(0, 0, 0);
        push_req(1, 0, 0);
        push_req(0, 5, 5);
        settle();

        load_atlas(4096, 4096, 63);
        run_glyphs(250);
        load_atlas(1, 1, 0);
        run_glyphs(120);
        load_atlas(64, 48, 2);
        run_glyphs(300);
        load_atlas(300, 4096, 0);
        run_glyphs(250);
        load_atlas(4096, 200, 5);
        run_glyphs(150);
        // narrower pages while shelves are still open
        load_atlas(100, 200, 5);
        run_glyphs(200);
        load_atlas(1024, 1024, 4);
        run_glyphs(620);

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (placement_q.size() != 0) begin
            $error("%0d results never arrived", placement_q.size());
            fails++;
        end
        $display("%0d requests over %0d atlas settings: %0d on open pages, %0d on new pages",
                 reqs_sent, settings_used, status_seen[ST_PLACED_OPEN],
                 status_seen[ST_PLACED_NEW]);
        $display("rejected %0d as too large, %0d with pages full, %0d clears",
                 status_seen[ST_TOO_LARGE], status_seen[ST_PAGES_FULL],
                 status_seen[ST_CLEARED]);
        if (fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
